### hw/rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
package hsv_pkg;

  // Hue and fraction constants
  localparam int unsigned HUE_FULL_TURN = 23040;  // 360 degrees in 1/64 degree units
  localparam int unsigned HUE_SECTOR    = 3840;   // 60 degrees
  localparam int unsigned FRAC_ONE      = 4096;   // 1.0 in the 12-bit hue fraction
  localparam int unsigned FRAC_DEN      = 255 * FRAC_ONE;

  // floor(rem * 16 / 15) == (rem * FRAC_RECIP) >> FRAC_SHIFT for rem < 3840
  localparam int unsigned FRAC_RECIP = 34953;
  localparam int unsigned FRAC_SHIFT = 15;

  // floor(y / 255) == (y * DIV255_RECIP) >> DIV255_SHIFT for y < 2**16
  localparam int unsigned DIV255_RECIP = 32897;
  localparam int unsigned DIV255_SHIFT = 23;

  // Rounding offsets: half of 255, half of 255*4096
  localparam int unsigned P_ROUND = 127;
  localparam int unsigned Q_ROUND = FRAC_DEN / 2;

  // Hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } hsv_sector_t;

  // Input pixel
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_pixel_t;

  // Output pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_rgb_t;

  // Hue split into sector and fraction
  typedef struct packed {
    hsv_sector_t sector;
    logic [11:0] frac;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_frac_t;

  // Rounded numerators of p, q and t, ready for the divide by 255
  typedef struct packed {
    hsv_sector_t sector;
    logic [7:0]  val;
    logic [15:0] yp;
    logic [15:0] yq;
    logic [15:0] yt;
  } hsv_num_t;

endpackage

### hw/rtl/hsv_sector.sv
// Two-stage hue split: wrap, sector select, then 12-bit fraction.
module hsv_sector (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  hsv_pkg::hsv_pixel_t pixel,
  output logic               valid_out,
  output hsv_pkg::hsv_frac_t frac_out
);

  logic [14:0]         hue_w;
  hsv_pkg::hsv_sector_t sector_next;
  logic [14:0]         base_next;
  logic [14:0]         rem_full;

  logic                valid1;
  hsv_pkg::hsv_sector_t sector1;
  logic [11:0]         rem1;
  logic [7:0]          sat1;
  logic [7:0]          val1;
  logic [27:0]         frac_prod;

  // Map a hue of a full turn or more to zero and pick the sector by compare
  always_comb begin
    hue_w = (pixel.hue >= 15'(hsv_pkg::HUE_FULL_TURN)) ? 15'd0 : pixel.hue;
    if (hue_w >= 15'(5 * hsv_pkg::HUE_SECTOR)) begin
      sector_next = hsv_pkg::SEC_MR;
      base_next   = 15'(5 * hsv_pkg::HUE_SECTOR);
    end else if (hue_w >= 15'(4 * hsv_pkg::HUE_SECTOR)) begin
      sector_next = hsv_pkg::SEC_BM;
      base_next   = 15'(4 * hsv_pkg::HUE_SECTOR);
    end else if (hue_w >= 15'(3 * hsv_pkg::HUE_SECTOR)) begin
      sector_next = hsv_pkg::SEC_CB;
      base_next   = 15'(3 * hsv_pkg::HUE_SECTOR);
    end else if (hue_w >= 15'(2 * hsv_pkg::HUE_SECTOR)) begin
      sector_next = hsv_pkg::SEC_GC;
      base_next   = 15'(2 * hsv_pkg::HUE_SECTOR);
    end else if (hue_w >= 15'(hsv_pkg::HUE_SECTOR)) begin
      sector_next = hsv_pkg::SEC_YG;
      base_next   = 15'(hsv_pkg::HUE_SECTOR);
    end else begin
      sector_next = hsv_pkg::SEC_RY;
      base_next   = 15'd0;
    end
    rem_full = hue_w - base_next;
  end

  // Stage 1: sector and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= valid_in;
    end
    sector1 <= sector_next;
    rem1    <= rem_full[11:0];
    sat1    <= pixel.saturation;
    val1    <= pixel.brightness;
  end

  // Scale remainder to a 12-bit fraction by reciprocal multiply
  assign frac_prod = 28'(rem1) * 28'(hsv_pkg::FRAC_RECIP);

  // Stage 2: fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid1;
    end
    frac_out.sector <= sector1;
    frac_out.frac   <= frac_prod[hsv_pkg::FRAC_SHIFT +: 12];
    frac_out.sat    <= sat1;
    frac_out.val    <= val1;
  end

endmodule

### hw/rtl/hsv_product.sv
// Three-stage fixed-point product path for p, q and t numerators.
module hsv_product (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  hsv_pkg::hsv_frac_t frac_in,
  output logic               valid_out,
  output hsv_pkg::hsv_num_t  num_out
);

  logic [19:0] sf_prod;
  logic [20:0] sg_prod;
  logic [12:0] frac_inv;

  logic                 valid_a;
  hsv_pkg::hsv_sector_t sector_a;
  logic [7:0]           val_a;
  logic [7:0]           np_a;
  logic [19:0]          nq_a;
  logic [19:0]          nt_a;

  logic                 valid_b;
  hsv_pkg::hsv_sector_t sector_b;
  logic [7:0]           val_b;
  logic [15:0]          xp_b;
  logic [27:0]          xq_b;
  logic [27:0]          xt_b;

  logic [28:0]          q_sum;
  logic [28:0]          t_sum;

  // Saturation times fraction and times its complement
  always_comb begin
    frac_inv = 13'(hsv_pkg::FRAC_ONE) - {1'b0, frac_in.frac};
    sf_prod  = 20'(frac_in.sat) * 20'(frac_in.frac);
    sg_prod  = 21'(frac_in.sat) * 21'(frac_inv);
  end

  // Stage A: numerators before the value multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= valid_in;
    end
    sector_a <= frac_in.sector;
    val_a    <= frac_in.val;
    np_a     <= 8'd255 - frac_in.sat;
    nq_a     <= 20'(hsv_pkg::FRAC_DEN) - sf_prod;
    nt_a     <= 20'(21'(hsv_pkg::FRAC_DEN) - sg_prod);
  end

  // Stage B: scale by value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
    sector_b <= sector_a;
    val_b    <= val_a;
    xp_b     <= 16'(val_a) * 16'(np_a);
    xq_b     <= 28'(val_a) * 28'(nq_a);
    xt_b     <= 28'(val_a) * 28'(nt_a);
  end

  // Add half the divisor; drop the power-of-two part of 255*4096
  assign q_sum = 29'(xq_b) + 29'(hsv_pkg::Q_ROUND);
  assign t_sum = 29'(xt_b) + 29'(hsv_pkg::Q_ROUND);

  // Stage C: rounded numerators over 255
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_b;
    end
    num_out.sector <= sector_b;
    num_out.val    <= val_b;
    num_out.yp     <= xp_b + 16'(hsv_pkg::P_ROUND);
    num_out.yq     <= q_sum[27:12];
    num_out.yt     <= t_sum[27:12];
  end

endmodule

### hw/rtl/hsv_div255.sv
// Registered divide by 255 through a reciprocal multiply.
module hsv_div255 (
  input  logic        clk,
  input  logic [15:0] dividend,
  output logic [7:0]  quotient
);

  logic [31:0] prod;

  // Hold the product for one stage, then shift
  always_ff @(posedge clk) begin
    prod <= 32'(dividend) * 32'(hsv_pkg::DIV255_RECIP);
  end

  assign quotient = prod[hsv_pkg::DIV255_SHIFT +: 8];

endmodule

### hw/rtl/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB pixel converter.
// Converts one HSV pixel per clock. A pixel is taken at each rising edge with
// start high and busy low; busy never rises, so a new pixel may follow every
// cycle. Its RGB result appears on result, marked by result_valid for exactly
// one cycle, once the pixel has passed all stages: two stages split the hue into
// sector and fraction, three stages form and round the p, q and t numerators,
// one stage holds the divide-by-255 reciprocal products and one registers the
// six-sector assignment. Results come out in input order and must be taken
// when shown; there is no result buffering.
module hsv_to_rgb_converter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hsv_pkg::hsv_pixel_t pixel,
  output logic                result_valid,
  output hsv_pkg::hsv_rgb_t   result
);

  logic               frac_valid;
  hsv_pkg::hsv_frac_t frac_data;
  logic               num_valid;
  hsv_pkg::hsv_num_t  num_data;

  logic                 div_valid;
  hsv_pkg::hsv_sector_t div_sector;
  logic [7:0]           div_val;
  logic [7:0]           p_q;
  logic [7:0]           q_q;
  logic [7:0]           t_q;

  hsv_pkg::hsv_rgb_t    rgb_next;

  // Pipeline never stalls
  assign busy = 1'b0;

  hsv_sector u_sector (
    .clk      (clk),
    .rst      (rst),
    .valid_in (start && !busy),
    .pixel    (pixel),
    .valid_out(frac_valid),
    .frac_out (frac_data)
  );

  hsv_product u_product (
    .clk      (clk),
    .rst      (rst),
    .valid_in (frac_valid),
    .frac_in  (frac_data),
    .valid_out(num_valid),
    .num_out  (num_data)
  );

  hsv_div255 u_div_p (.clk(clk), .dividend(num_data.yp), .quotient(p_q));
  hsv_div255 u_div_q (.clk(clk), .dividend(num_data.yq), .quotient(q_q));
  hsv_div255 u_div_t (.clk(clk), .dividend(num_data.yt), .quotient(t_q));

  // Carry sector and value alongside the divider stage
  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else begin
      div_valid <= num_valid;
    end
    div_sector <= num_data.sector;
    div_val    <= num_data.val;
  end

  // Place v, p, q and t by sector
  always_comb begin
    case (div_sector)
      hsv_pkg::SEC_RY: rgb_next = '{red: div_val, green: t_q,     blue: p_q};
      hsv_pkg::SEC_YG: rgb_next = '{red: q_q,     green: div_val, blue: p_q};
      hsv_pkg::SEC_GC: rgb_next = '{red: p_q,     green: div_val, blue: t_q};
      hsv_pkg::SEC_CB: rgb_next = '{red: p_q,     green: q_q,     blue: div_val};
      hsv_pkg::SEC_BM: rgb_next = '{red: t_q,     green: p_q,     blue: div_val};
      default:         rgb_next = '{red: div_val, green: p_q,     blue: q_q};
    endcase
  end

  // Output register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= div_valid;
    end
    result <= rgb_next;
  end

endmodule

### hw/rtl/hsv_to_rgb_converter_checker.sv
// Port-level checks of the HSV to RGB converter, bound to the top level.
module hsv_to_rgb_converter_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input hsv_pkg::hsv_pixel_t pixel,
  input logic                result_valid,
  input hsv_pkg::hsv_rgb_t   result
);

  // Every accepted transfer gives a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 result_valid)
    else $error("accepted pixel produced no result");

  // No result without an earlier accepted transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 7))
    else $error("result without an accepted pixel");

  // Zero saturation yields grey at the input brightness
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(pixel.saturation == 8'd0, 7)) |->
      (result.red == $past(pixel.brightness, 7) && result.green == result.red &&
       result.blue == result.red))
    else $error("zero saturation did not give grey");

  // The largest channel equals brightness and none exceeds it
  a_max_is_value: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.red <= $past(pixel.brightness, 7) &&
       result.green <= $past(pixel.brightness, 7) &&
       result.blue <= $past(pixel.brightness, 7) &&
       (result.red == $past(pixel.brightness, 7) ||
        result.green == $past(pixel.brightness, 7) ||
        result.blue == $past(pixel.brightness, 7))))
    else $error("channel range does not match brightness");

endmodule

bind hsv_to_rgb_converter_unit hsv_to_rgb_converter_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .pixel       (pixel),
  .result_valid(result_valid),
  .result      (result)
);
